// File: sv/cbe_pkg.sv
// Shared types, constants and helpers of the cubic Bezier evaluator.
package cbe_pkg;

  localparam int COORD_BITS = 32;
  localparam int TAN_BITS   = COORD_BITS + 4;
  localparam int BEND_BITS  = COORD_BITS + 6;
  localparam int F_BITS     = 16;
  localparam int T_BITS     = F_BITS + 1;
  localparam int IDX_BITS   = 8;
  localparam int CNT_BITS   = 9;
  localparam int W_BITS     = 22;
  localparam int PROD_BITS  = W_BITS + COORD_BITS;
  localparam int ACC_BITS   = PROD_BITS + 2;
  localparam int RND_BITS   = ACC_BITS - F_BITS;
  localparam int MAX_POINTS = 256;
  localparam int VEC_BITS   = 3 * COORD_BITS;

  localparam logic [T_BITS-1:0]   T_ONE      = T_BITS'(1) << F_BITS;
  localparam logic [CNT_BITS-1:0] MIN_KNOTS  = CNT_BITS'(2);
  localparam logic [CNT_BITS-1:0] MAX_KNOTS  = CNT_BITS'(MAX_POINTS);
  localparam logic [2:0]          EVAL_LAST  = 3'd5;

  typedef enum logic [1:0] {
    MODE_LOAD   = 2'd0,
    MODE_SEG    = 2'd1,
    MODE_GLOBAL = 2'd2,
    MODE_NONE   = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    KIND_KNOT = 2'd0,
    KIND_IN   = 2'd1,
    KIND_OUT  = 2'd2,
    KIND_NONE = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    OP_LOAD,
    OP_EVAL,
    OP_FLAG
  } op_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_EVAL,
    BK_DONE
  } back_state_t;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [W_BITS-1:0]     weight_t;

  // One classified item as it travels from the front part to the back part.
  typedef struct packed {
    op_t                  op;
    logic [1:0]           kind;
    logic [IDX_BITS-1:0]  idx;
    logic [IDX_BITS-1:0]  seg;
    coord_t               x;
    coord_t               y;
    coord_t               z;
    weight_t [3:0]        wp;
    weight_t [3:0]        wt;
    weight_t [3:0]        wb;
    logic [IDX_BITS-1:0]  iused;
    logic                 status;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // Round half up and drop the fraction bits of a 36-bit product.
  function automatic logic [19:0] rnd36(input logic [35:0] p);
    logic [35:0] s;
    s = p + (36'd1 << (F_BITS - 1));
    return s[35:F_BITS];
  endfunction

endpackage

// File: sv/cubic_bezier_evaluator_top.sv
// Top level of the cubic Bezier evaluator.
// Usage:
// Items enter on the in_ channel (push/full) and results leave on the out_
// channel (empty/pop); every item gives exactly one result, in order.
// A load writes one knot, incoming or outgoing handle vector into the stores.
// An evaluate item returns the point, first and second derivative of one
// interval, picked directly or from a global parameter.
// The knot count register is written on the cfg_ channel (valid/ready, ready
// is always high); write it only while the block is idle, the block does not enforce this.
// The back sequencer handles one item at a time: for an evaluation it reads four
// vectors from the stores and runs them through the nine multiply-accumulate
// lanes before it takes the next item from the queue.
// The front keeps accepting while a result waits; when out_pop stays low the
// result register, the two-entry queue and the front fill and full rises.
// Synchronous reset empties all stages and sets the knot count to 2; the
// vector stores are not cleared and must be loaded before use.
module cubic_bezier_evaluator_top (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_push,
  output logic                                 in_full,
  input  logic [1:0]                           in_mode,
  input  logic [cbe_pkg::IDX_BITS-1:0]         in_entry_index,
  input  logic [1:0]                           in_vector_kind,
  input  logic signed [cbe_pkg::COORD_BITS-1:0] in_coord_x,
  input  logic signed [cbe_pkg::COORD_BITS-1:0] in_coord_y,
  input  logic signed [cbe_pkg::COORD_BITS-1:0] in_coord_z,
  input  logic [cbe_pkg::T_BITS-1:0]           in_param_t,
  output logic                                 out_empty,
  input  logic                                 out_pop,
  output logic signed [cbe_pkg::COORD_BITS-1:0] out_point_x,
  output logic signed [cbe_pkg::COORD_BITS-1:0] out_point_y,
  output logic signed [cbe_pkg::COORD_BITS-1:0] out_point_z,
  output logic signed [cbe_pkg::TAN_BITS-1:0]  out_tangent_x,
  output logic signed [cbe_pkg::TAN_BITS-1:0]  out_tangent_y,
  output logic signed [cbe_pkg::TAN_BITS-1:0]  out_tangent_z,
  output logic signed [cbe_pkg::BEND_BITS-1:0] out_bend_x,
  output logic signed [cbe_pkg::BEND_BITS-1:0] out_bend_y,
  output logic signed [cbe_pkg::BEND_BITS-1:0] out_bend_z,
  output logic [cbe_pkg::IDX_BITS-1:0]         out_interval_used,
  output logic                                 out_status,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [cbe_pkg::CNT_BITS-1:0]         cfg_data
);

  logic [cbe_pkg::CNT_BITS-1:0] points_r, points_nxt;
  logic                         q_push, q_pop;
  cbe_pkg::cmd_t                q_cmd, q_head;
  cbe_pkg::q_stat_t             q_stat;

  assign cfg_ready  = 1'b1;
  assign points_nxt = (cfg_valid && cfg_ready) ? cfg_data : points_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      points_r <= cbe_pkg::MIN_KNOTS;
    end else begin
      points_r <= points_nxt;
    end
  end

  cbe_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_mode        (in_mode),
    .in_entry_index (in_entry_index),
    .in_vector_kind (in_vector_kind),
    .in_coord_x     (in_coord_x),
    .in_coord_y     (in_coord_y),
    .in_coord_z     (in_coord_z),
    .in_param_t     (in_param_t),
    .points         (points_r),
    .q_stat         (q_stat),
    .q_push         (q_push),
    .q_cmd          (q_cmd)
  );

  cbe_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_cmd),
    .pop      (q_pop),
    .head     (q_head),
    .stat     (q_stat)
  );

  cbe_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .head              (q_head),
    .q_stat            (q_stat),
    .q_pop             (q_pop),
    .out_empty         (out_empty),
    .out_pop           (out_pop),
    .out_point_x       (out_point_x),
    .out_point_y       (out_point_y),
    .out_point_z       (out_point_z),
    .out_tangent_x     (out_tangent_x),
    .out_tangent_y     (out_tangent_y),
    .out_tangent_z     (out_tangent_z),
    .out_bend_x        (out_bend_x),
    .out_bend_y        (out_bend_y),
    .out_bend_z        (out_bend_z),
    .out_interval_used (out_interval_used),
    .out_status        (out_status)
  );

endmodule

// File: sv/cbe_front.sv
// Front part: accepts items, maps the parameter and builds Bernstein weights.
module cbe_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_push,
  output logic                          in_full,
  input  logic [1:0]                    in_mode,
  input  logic [cbe_pkg::IDX_BITS-1:0]  in_entry_index,
  input  logic [1:0]                    in_vector_kind,
  input  cbe_pkg::coord_t               in_coord_x,
  input  cbe_pkg::coord_t               in_coord_y,
  input  cbe_pkg::coord_t               in_coord_z,
  input  logic [cbe_pkg::T_BITS-1:0]    in_param_t,
  input  logic [cbe_pkg::CNT_BITS-1:0]  points,
  input  cbe_pkg::q_stat_t              q_stat,
  output logic                          q_push,
  output cbe_pkg::cmd_t                 q_cmd
);

  typedef struct packed {
    cbe_pkg::op_t                  op;
    logic [1:0]                    kind;
    logic [cbe_pkg::IDX_BITS-1:0]  idx;
    logic [cbe_pkg::IDX_BITS-1:0]  seg;
    logic [cbe_pkg::T_BITS-1:0]    u;
    cbe_pkg::coord_t               x;
    cbe_pkg::coord_t               y;
    cbe_pkg::coord_t               z;
    logic [cbe_pkg::IDX_BITS-1:0]  iused;
    logic                          status;
  } front_t;

  logic                          adv;
  logic                          accept;
  logic                          a_v_r, a_v_nxt, b_v_r, b_v_nxt;
  front_t                        a_r, a_nxt, b_r;
  logic [cbe_pkg::T_BITS-1:0]    b_v_w_r, a_v_w;
  logic [cbe_pkg::T_BITS-1:0]    uu_r, vv_r, uv_r;
  logic [cbe_pkg::CNT_BITS-1:0]  knots;
  logic [cbe_pkg::IDX_BITS-1:0]  intervals, last_seg, gseg;
  logic [cbe_pkg::T_BITS-1:0]    tc;
  logic [cbe_pkg::T_BITS+cbe_pkg::IDX_BITS-1:0] e;
  logic [cbe_pkg::CNT_BITS-1:0]  e_seg;
  logic [cbe_pkg::T_BITS+cbe_pkg::IDX_BITS-1:0] e_base;
  logic [19:0]                   wp0, wp1, wp2, wp3;

  // The pipeline moves only when its last stage can hand its item on.
  assign adv     = !(b_v_r && q_stat.full);
  assign in_full = !adv;
  assign accept  = in_push && !in_full;
  assign q_push  = b_v_r && !q_stat.full;

  always_comb begin
    if (points < cbe_pkg::MIN_KNOTS) begin
      knots = cbe_pkg::MIN_KNOTS;
    end else if (points > cbe_pkg::MAX_KNOTS) begin
      knots = cbe_pkg::MAX_KNOTS;
    end else begin
      knots = points;
    end
    intervals = cbe_pkg::IDX_BITS'(knots - cbe_pkg::CNT_BITS'(1));
    last_seg  = intervals - cbe_pkg::IDX_BITS'(1);
    tc        = (in_param_t > cbe_pkg::T_ONE) ? cbe_pkg::T_ONE : in_param_t;
    e         = tc * intervals;
    e_seg     = e[cbe_pkg::T_BITS+cbe_pkg::IDX_BITS-1:cbe_pkg::F_BITS];
    gseg      = (e_seg > cbe_pkg::CNT_BITS'(last_seg)) ? last_seg
                                                       : cbe_pkg::IDX_BITS'(e_seg);
    e_base    = {1'b0, gseg, {cbe_pkg::F_BITS{1'b0}}};
  end

  always_comb begin
    a_nxt        = '0;
    a_nxt.kind   = in_vector_kind;
    a_nxt.idx    = in_entry_index;
    a_nxt.x      = in_coord_x;
    a_nxt.y      = in_coord_y;
    a_nxt.z      = in_coord_z;
    unique case (cbe_pkg::mode_t'(in_mode))
      cbe_pkg::MODE_LOAD: begin
        if (cbe_pkg::kind_t'(in_vector_kind) == cbe_pkg::KIND_NONE) begin
          a_nxt.op     = cbe_pkg::OP_FLAG;
          a_nxt.status = 1'b1;
        end else begin
          a_nxt.op = cbe_pkg::OP_LOAD;
        end
      end
      cbe_pkg::MODE_SEG: begin
        if (in_entry_index >= intervals) begin
          a_nxt.op     = cbe_pkg::OP_FLAG;
          a_nxt.status = 1'b1;
          a_nxt.iused  = in_entry_index;
        end else begin
          a_nxt.op    = cbe_pkg::OP_EVAL;
          a_nxt.seg   = in_entry_index;
          a_nxt.iused = in_entry_index;
          a_nxt.u     = tc;
        end
      end
      cbe_pkg::MODE_GLOBAL: begin
        a_nxt.op    = cbe_pkg::OP_EVAL;
        a_nxt.seg   = gseg;
        a_nxt.iused = gseg;
        a_nxt.u     = cbe_pkg::T_BITS'(e - e_base);
      end
      default: begin
        a_nxt.op     = cbe_pkg::OP_FLAG;
        a_nxt.status = 1'b1;
      end
    endcase
  end

  assign a_v_nxt = adv ? accept : a_v_r;
  assign b_v_nxt = adv ? a_v_r : b_v_r;
  assign a_v_w   = cbe_pkg::T_ONE - a_r.u;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
    end else begin
      a_v_r <= a_v_nxt;
      b_v_r <= b_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_r     <= a_nxt;
      b_r     <= a_r;
      b_v_w_r <= a_v_w;
      uu_r    <= cbe_pkg::T_BITS'(cbe_pkg::rnd36(36'(a_r.u) * 36'(a_r.u)));
      vv_r    <= cbe_pkg::T_BITS'(cbe_pkg::rnd36(36'(a_v_w) * 36'(a_v_w)));
      uv_r    <= cbe_pkg::T_BITS'(cbe_pkg::rnd36(36'(a_r.u) * 36'(a_v_w)));
    end
  end

  assign wp0 = cbe_pkg::rnd36(36'(b_v_w_r) * 36'(vv_r));
  assign wp1 = cbe_pkg::rnd36(36'(3) * (36'(b_r.u) * 36'(vv_r)));
  assign wp2 = cbe_pkg::rnd36(36'(3) * (36'(uu_r) * 36'(b_v_w_r)));
  assign wp3 = cbe_pkg::rnd36(36'(b_r.u) * 36'(uu_r));

  always_comb begin
    cbe_pkg::weight_t u_s, v_s, uu_s, vv_s, uv_s;
    u_s  = cbe_pkg::W_BITS'(b_r.u);
    v_s  = cbe_pkg::W_BITS'(b_v_w_r);
    uu_s = cbe_pkg::W_BITS'(uu_r);
    vv_s = cbe_pkg::W_BITS'(vv_r);
    uv_s = cbe_pkg::W_BITS'(uv_r);
    q_cmd        = '0;
    q_cmd.op     = b_r.op;
    q_cmd.kind   = b_r.kind;
    q_cmd.idx    = b_r.idx;
    q_cmd.seg    = b_r.seg;
    q_cmd.x      = b_r.x;
    q_cmd.y      = b_r.y;
    q_cmd.z      = b_r.z;
    q_cmd.iused  = b_r.iused;
    q_cmd.status = b_r.status;
    q_cmd.wp[0]  = cbe_pkg::W_BITS'(wp0);
    q_cmd.wp[1]  = cbe_pkg::W_BITS'(wp1);
    q_cmd.wp[2]  = cbe_pkg::W_BITS'(wp2);
    q_cmd.wp[3]  = cbe_pkg::W_BITS'(wp3);
    q_cmd.wt[0]  = cbe_pkg::W_BITS'(-(3 * vv_s));
    q_cmd.wt[1]  = cbe_pkg::W_BITS'(3 * vv_s - 6 * uv_s);
    q_cmd.wt[2]  = cbe_pkg::W_BITS'(6 * uv_s - 3 * uu_s);
    q_cmd.wt[3]  = cbe_pkg::W_BITS'(3 * uu_s);
    q_cmd.wb[0]  = cbe_pkg::W_BITS'(6 * v_s);
    q_cmd.wb[1]  = cbe_pkg::W_BITS'(6 * u_s - 12 * v_s);
    q_cmd.wb[2]  = cbe_pkg::W_BITS'(6 * v_s - 12 * u_s);
    q_cmd.wb[3]  = cbe_pkg::W_BITS'(6 * u_s);
  end

endmodule

// File: sv/cbe_queue.sv
// Two-entry command queue between the front and back parts.
module cbe_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  cbe_pkg::cmd_t     push_cmd,
  input  logic              pop,
  output cbe_pkg::cmd_t     head,
  output cbe_pkg::q_stat_t  stat
);

  cbe_pkg::cmd_t  slot_r [2];
  logic           wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [1:0]     cnt_r, cnt_nxt;

  assign stat.full  = (cnt_r == 2'd2);
  assign stat.empty = (cnt_r == 2'd0);
  assign head       = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? !rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// File: sv/cbe_back.sv
// Back part: vector stores, blend datapath and the result register.
module cbe_back (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  cbe_pkg::cmd_t                        head,
  input  cbe_pkg::q_stat_t                     q_stat,
  output logic                                 q_pop,
  output logic                                 out_empty,
  input  logic                                 out_pop,
  output cbe_pkg::coord_t                      out_point_x,
  output cbe_pkg::coord_t                      out_point_y,
  output cbe_pkg::coord_t                      out_point_z,
  output logic signed [cbe_pkg::TAN_BITS-1:0]  out_tangent_x,
  output logic signed [cbe_pkg::TAN_BITS-1:0]  out_tangent_y,
  output logic signed [cbe_pkg::TAN_BITS-1:0]  out_tangent_z,
  output logic signed [cbe_pkg::BEND_BITS-1:0] out_bend_x,
  output logic signed [cbe_pkg::BEND_BITS-1:0] out_bend_y,
  output logic signed [cbe_pkg::BEND_BITS-1:0] out_bend_z,
  output logic [cbe_pkg::IDX_BITS-1:0]         out_interval_used,
  output logic                                 out_status
);

  localparam int RB = cbe_pkg::RND_BITS;

  cbe_pkg::back_state_t state_r, state_nxt;
  logic [2:0]             cnt_r, cnt_nxt;
  cbe_pkg::cmd_t          cmd_r;
  logic                   out_valid_r, out_valid_nxt;
  logic                   mem_we, done_go;
  logic [cbe_pkg::IDX_BITS-1:0] knot_addr, next_seg;
  logic [cbe_pkg::VEC_BITS-1:0] knot_mem [cbe_pkg::MAX_POINTS];
  logic [cbe_pkg::VEC_BITS-1:0] in_mem   [cbe_pkg::MAX_POINTS];
  logic [cbe_pkg::VEC_BITS-1:0] out_mem  [cbe_pkg::MAX_POINTS];
  logic [cbe_pkg::VEC_BITS-1:0] knot_rd_r, in_rd_r, out_rd_r, vec;
  logic [cbe_pkg::VEC_BITS-1:0] wr_vec;
  logic [1:0]             term;
  logic signed [cbe_pkg::PROD_BITS-1:0] prod_r [9];
  logic signed [cbe_pkg::ACC_BITS-1:0]  acc_r  [9];
  logic signed [RB-1:0]   res [9];

  function automatic logic signed [RB-1:0] sat_to(input logic signed [RB-1:0] v,
                                                  input int b);
    logic signed [RB-1:0] hi, lo;
    hi = (RB'(1) <<< (b - 1)) - RB'(1);
    lo = -hi - RB'(1);
    if (v > hi) begin
      return hi;
    end else if (v < lo) begin
      return lo;
    end
    return v;
  endfunction

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      cbe_pkg::BK_IDLE: begin
        if (!q_stat.empty) begin
          state_nxt = (head.op == cbe_pkg::OP_EVAL) ? cbe_pkg::BK_EVAL : cbe_pkg::BK_DONE;
        end
      end
      cbe_pkg::BK_EVAL: begin
        if (cnt_r == cbe_pkg::EVAL_LAST) begin
          state_nxt = cbe_pkg::BK_DONE;
        end
      end
      cbe_pkg::BK_DONE: begin
        if (done_go) begin
          state_nxt = cbe_pkg::BK_IDLE;
        end
      end
      default: state_nxt = cbe_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    q_pop   = (state_r == cbe_pkg::BK_IDLE) && !q_stat.empty;
    mem_we  = q_pop && (head.op == cbe_pkg::OP_LOAD);
    done_go = (state_r == cbe_pkg::BK_DONE) && (!out_valid_r || out_pop);
    cnt_nxt = (state_r == cbe_pkg::BK_EVAL) ? cnt_r + 3'd1 : 3'd0;
    out_valid_nxt = done_go ? 1'b1 : (out_pop ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cbe_pkg::BK_IDLE;
      cnt_r       <= 3'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cmd_r <= head;
    end
  end

  // Reads: knot[i], outgoing[i], incoming[i+1], knot[i+1] on counts 0 to 3.
  assign next_seg  = cmd_r.seg + cbe_pkg::IDX_BITS'(1);
  assign knot_addr = (cnt_r == 3'd0) ? cmd_r.seg : next_seg;
  assign wr_vec    = {head.x, head.y, head.z};

  always_ff @(posedge clk) begin
    if (mem_we && cbe_pkg::kind_t'(head.kind) == cbe_pkg::KIND_KNOT) begin
      knot_mem[head.idx] <= wr_vec;
    end
    knot_rd_r <= knot_mem[knot_addr];
  end

  always_ff @(posedge clk) begin
    if (mem_we && cbe_pkg::kind_t'(head.kind) == cbe_pkg::KIND_IN) begin
      in_mem[head.idx] <= wr_vec;
    end
    in_rd_r <= in_mem[next_seg];
  end

  always_ff @(posedge clk) begin
    if (mem_we && cbe_pkg::kind_t'(head.kind) == cbe_pkg::KIND_OUT) begin
      out_mem[head.idx] <= wr_vec;
    end
    out_rd_r <= out_mem[cmd_r.seg];
  end

  assign term = 2'(cnt_r - 3'd1);

  always_comb begin
    case (term)
      2'd1:    vec = out_rd_r;
      2'd2:    vec = in_rd_r;
      default: vec = knot_rd_r;
    endcase
  end

  // Nine lanes: point, tangent and bend for each coordinate. The sums are held
  // outside the evaluation so that a stalled result keeps its value.
  always_ff @(posedge clk) begin
    for (int d = 0; d < 3; d++) begin
      cbe_pkg::coord_t c;
      c = vec[(2 - d) * cbe_pkg::COORD_BITS +: cbe_pkg::COORD_BITS];
      prod_r[d]     <= $signed(cmd_r.wp[term]) * c;
      prod_r[3 + d] <= $signed(cmd_r.wt[term]) * c;
      prod_r[6 + d] <= $signed(cmd_r.wb[term]) * c;
    end
    for (int l = 0; l < 9; l++) begin
      if (state_r == cbe_pkg::BK_EVAL) begin
        if (cnt_r == 3'd2) begin
          acc_r[l] <= cbe_pkg::ACC_BITS'(prod_r[l]);
        end else if (cnt_r > 3'd2) begin
          acc_r[l] <= acc_r[l] + cbe_pkg::ACC_BITS'(prod_r[l]);
        end
      end
    end
  end

  always_comb begin
    for (int l = 0; l < 9; l++) begin
      logic signed [cbe_pkg::ACC_BITS-1:0] s;
      s = acc_r[l] + (cbe_pkg::ACC_BITS'(1) <<< (cbe_pkg::F_BITS - 1));
      res[l] = s[cbe_pkg::ACC_BITS-1:cbe_pkg::F_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (done_go) begin
      out_interval_used <= cmd_r.iused;
      out_status        <= cmd_r.status;
      if (cmd_r.op == cbe_pkg::OP_EVAL) begin
        out_point_x   <= cbe_pkg::COORD_BITS'(sat_to(res[0], cbe_pkg::COORD_BITS));
        out_point_y   <= cbe_pkg::COORD_BITS'(sat_to(res[1], cbe_pkg::COORD_BITS));
        out_point_z   <= cbe_pkg::COORD_BITS'(sat_to(res[2], cbe_pkg::COORD_BITS));
        out_tangent_x <= cbe_pkg::TAN_BITS'(sat_to(res[3], cbe_pkg::TAN_BITS));
        out_tangent_y <= cbe_pkg::TAN_BITS'(sat_to(res[4], cbe_pkg::TAN_BITS));
        out_tangent_z <= cbe_pkg::TAN_BITS'(sat_to(res[5], cbe_pkg::TAN_BITS));
        out_bend_x    <= cbe_pkg::BEND_BITS'(sat_to(res[6], cbe_pkg::BEND_BITS));
        out_bend_y    <= cbe_pkg::BEND_BITS'(sat_to(res[7], cbe_pkg::BEND_BITS));
        out_bend_z    <= cbe_pkg::BEND_BITS'(sat_to(res[8], cbe_pkg::BEND_BITS));
      end else begin
        out_point_x   <= '0;
        out_point_y   <= '0;
        out_point_z   <= '0;
        out_tangent_x <= '0;
        out_tangent_y <= '0;
        out_tangent_z <= '0;
        out_bend_x    <= '0;
        out_bend_y    <= '0;
        out_bend_z    <= '0;
      end
    end
  end

  assign out_empty = !out_valid_r;

  a_pop_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (state_r == cbe_pkg::BK_IDLE) && !q_stat.empty)
    else $error("command taken outside idle");

  a_eval_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == cbe_pkg::BK_EVAL && cnt_r == cbe_pkg::EVAL_LAST) |=>
      state_r == cbe_pkg::BK_DONE)
    else $error("evaluation did not finish on time");

  a_done_waits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == cbe_pkg::BK_DONE && out_valid_r && !out_pop) |=>
      state_r == cbe_pkg::BK_DONE && out_valid_r)
    else $error("result overwritten while waiting");

endmodule
